// ===== src/b64e_pkg.sv =====
// b64e_pkg: shared types, constants and the symbol lookup for the base64 stream encoder
// no dependencies; imported by every module of the encoder
package b64e_pkg;

  // position within a three-byte group
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // job queue between front and back
  localparam int JQ_DEPTH = 2;
  localparam int JQ_PTR_W = $clog2(JQ_DEPTH);
  localparam int JQ_CNT_W = $clog2(JQ_DEPTH + 1);

  // characters produced by one input byte, oldest in slot 0
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            msg_end;
  } job_t;

  // six-bit value to its base64 ascii character
  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== src/base64_stream_encoder_top.sv =====
// channel   | direction | handshake        | payload
// input     | in        | push / full      | data_byte, end_of_message
// result    | out       | empty / pop      | out_char, last_char
//
// a byte produces one or two characters mid-message and two to four on its last byte;
// the result register emits one character per cycle while pop is high and a job waits,
// so that single result port sets the encoder's byte throughput in steady state.
// first character goes via a job queue entry, then the result register, to the ports.
// synchronous reset clears group phase, job queue and result register; no clearing pass.
// full rises only when the two-entry job queue holds two jobs; a stalled result side
// fills it.
//
// base64_stream_encoder_top: connects front, job queue and back
// depends on b64e_pkg, b64e_front, b64e_job_fifo, b64e_back
module base64_stream_encoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       last_char
);
  import b64e_pkg::*;

  logic take;
  job_t front_job;
  job_t head_job;
  logic job_avail;
  logic job_pop;

  // input transaction
  assign take = push && !full;

  b64e_front u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .job            (front_job)
  );

  b64e_job_fifo u_job_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (take),
    .wr_job (front_job),
    .rd_en  (job_pop),
    .rd_job (head_job),
    .full   (full),
    .avail  (job_avail)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .job_avail (job_avail),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .out_char  (out_char),
    .last_char (last_char)
  );

endmodule

// ===== src/b64e_front.sv =====
// b64e_front: accepts raw bytes, tracks group phase and leftover bits, builds character jobs
// depends on b64e_pkg
module b64e_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [7:0]     data_byte,
  input  logic           end_of_message,
  output b64e_pkg::job_t job
);
  import b64e_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] leftover;
  logic [3:0] leftover_next;

  // next phase and leftover bits
  always_comb begin
    phase_next    = phase;
    leftover_next = leftover;
    if (end_of_message) begin
      phase_next    = PH_FIRST;
      leftover_next = 4'd0;
    end else begin
      unique case (phase)
        PH_SECOND: begin
          phase_next    = PH_THIRD;
          leftover_next = data_byte[3:0];
        end
        PH_THIRD: begin
          phase_next    = PH_FIRST;
          leftover_next = 4'd0;
        end
        default: begin
          phase_next    = PH_SECOND;
          leftover_next = {2'b00, data_byte[1:0]};
        end
      endcase
    end
  end

  // characters for this byte, padded on the last byte of a message
  always_comb begin
    job.chars    = {4{PAD_CHAR}};
    job.last_idx = 2'd0;
    job.msg_end  = end_of_message;
    unique case (phase)
      PH_SECOND: begin
        job.chars[0] = sym({leftover[1:0], data_byte[7:4]});
        if (end_of_message) begin
          job.chars[1] = sym({data_byte[3:0], 2'b00});
          job.last_idx = 2'd2;
        end
      end
      PH_THIRD: begin
        job.chars[0] = sym({leftover[3:0], data_byte[7:6]});
        job.chars[1] = sym(data_byte[5:0]);
        job.last_idx = 2'd1;
      end
      default: begin
        job.chars[0] = sym(data_byte[7:2]);
        if (end_of_message) begin
          job.chars[1] = sym({data_byte[1:0], 4'b0000});
          job.last_idx = 2'd3;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_FIRST;
      leftover <= 4'd0;
    end else if (take) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

endmodule

// ===== src/b64e_job_fifo.sv =====
// b64e_job_fifo: short queue of character jobs between front and back
// depends on b64e_pkg
module b64e_job_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  b64e_pkg::job_t wr_job,
  input  logic           rd_en,
  output b64e_pkg::job_t rd_job,
  output logic           full,
  output logic           avail
);
  import b64e_pkg::*;

  job_t                entries [JQ_DEPTH];
  logic [JQ_PTR_W-1:0] wr_ptr;
  logic [JQ_PTR_W-1:0] rd_ptr;
  logic [JQ_CNT_W-1:0] count;

  assign full   = (count == JQ_CNT_W'(JQ_DEPTH));
  assign avail  = (count != '0);
  assign rd_job = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == JQ_PTR_W'(JQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == JQ_PTR_W'(JQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/b64e_back.sv =====
// b64e_back: walks the characters of the head job out through a one-entry output register
// depends on b64e_pkg
module b64e_back (
  input  logic           clk,
  input  logic           rst,
  input  b64e_pkg::job_t job,
  input  logic           job_avail,
  output logic           job_pop,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     out_char,
  output logic           last_char
);
  import b64e_pkg::*;

  logic [1:0] sel;
  logic       out_valid;
  logic       load;
  logic       at_end;

  // load a character when the output register is free or being drained
  assign load    = job_avail && (!out_valid || pop);
  assign at_end  = (sel == job.last_idx);
  assign job_pop = load && at_end;
  assign empty   = !out_valid;

  // character select and valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      sel       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        sel       <= at_end ? 2'd0 : sel + 2'd1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_char  <= job.chars[sel];
      last_char <= job.msg_end && at_end;
    end
  end

endmodule

// ===== src/b64e_checker.sv =====
// b64e_checker: port-level assertions for the base64 stream encoder, bound to the top level
// depends on base64_stream_encoder_top
module b64e_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char,
  input logic       last_char
);

  // reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("encoder not idle after reset");

  // a stalled result transaction holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(last_char)))
    else $error("result changed while stalled");

  // every character is from the alphabet or the pad
  a_legal_char: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((out_char >= 8'h41 && out_char <= 8'h5A) ||
                (out_char >= 8'h61 && out_char <= 8'h7A) ||
                (out_char >= 8'h30 && out_char <= 8'h39) ||
                out_char == 8'h2B || out_char == 8'h2F || out_char == 8'h3D))
    else $error("illegal output character");

  // a pad that is not final is followed at once by the final pad
  a_double_pad: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && out_char == 8'h3D && !last_char)
      |=> (!empty && out_char == 8'h3D && last_char))
    else $error("first pad not followed by final pad");

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_char  (out_char),
  .last_char (last_char)
);
